@@ rtl/gh_pkg.sv @@
// shared types and constants for the graham scan convex hull block
// no dependencies; imported by every rtl module of the block except gh_ram
package gh_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;
    localparam int IDX_BITS   = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int L1_BITS    = COORD_BITS + 2;
    localparam int PT_BITS    = 2 * COORD_BITS;

    // one stored point
    typedef struct packed {
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } point_t;

    // one hull job handed from the loader to the engine
    typedef struct packed {
        logic [CNT_BITS-1:0] n;
        logic                ovf;
    } job_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_PIV,
        B_LDI,
        B_LDW,
        B_RANK,
        B_WRS,
        B_SRD,
        B_SWT,
        B_TEST,
        B_OWAIT,
        B_POPW,
        B_ERD,
        B_EWT
    } back_state_t;

endpackage

@@ rtl/gh_ram.sv @@
// generic single write port ram with one registered read port
// no dependencies
module gh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/gh_front.sv @@
// point loader: accepts input beats, fills the point store, raises hull jobs
// depends on gh_pkg
module gh_front import gh_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_px,
    input  logic [COORD_BITS-1:0] s_py,
    input  logic                  s_final_point,
    input  logic                  hold,
    output logic                  pt_we,
    output logic [IDX_BITS-1:0]   pt_waddr,
    output point_t                pt_wdata,
    output logic                  push,
    output job_t                  push_job
);

    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic                full;
    logic                accept;

    assign s_ready = !hold;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CNT_BITS'(MAX_POINTS));

    // store write and job hand-off
    always_comb begin
        pt_we       = accept && !full;
        pt_waddr    = count_reg[IDX_BITS-1:0];
        pt_wdata.x  = s_px;
        pt_wdata.y  = s_py;
        push        = accept && s_final_point;
        push_job.n  = full ? count_reg : count_reg + CNT_BITS'(1);
        push_job.ovf = ovf_reg || full;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        if (accept) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                count_next = count_reg + CNT_BITS'(1);
            end
            if (s_final_point) begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

@@ rtl/gh_queue.sv @@
// two entry job queue between the loader and the hull engine
// depends on gh_pkg
module gh_queue import gh_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic valid,
    output job_t pop_job
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign valid   = (cnt_reg != 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign pop_job = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

@@ rtl/gh_orient.sv @@
// pipelined orientation test: sign of (a - o) x (b - o), two register stages
// depends on gh_pkg
module gh_orient import gh_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    input  point_t o,
    input  point_t a,
    input  point_t b,
    output logic   out_valid,
    output logic   out_pos,
    output logic   out_zero
);

    logic signed [DIFF_BITS-1:0] dax_reg, day_reg, dbx_reg, dby_reg;
    logic signed [PROD_BITS-1:0] p1_reg, p2_reg;
    logic                        v1_reg, v2_reg;

    // stage one: differences
    always_ff @(posedge aclk) begin
        dax_reg <= DIFF_BITS'(a.x) - DIFF_BITS'(o.x);
        day_reg <= DIFF_BITS'(a.y) - DIFF_BITS'(o.y);
        dbx_reg <= DIFF_BITS'(b.x) - DIFF_BITS'(o.x);
        dby_reg <= DIFF_BITS'(b.y) - DIFF_BITS'(o.y);
        // stage two: cross products
        p1_reg  <= PROD_BITS'(dax_reg) * PROD_BITS'(dby_reg);
        p2_reg  <= PROD_BITS'(day_reg) * PROD_BITS'(dbx_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_pos   = (p1_reg > p2_reg);
    assign out_zero  = (p1_reg == p2_reg);

endmodule

@@ rtl/gh_back.sv @@
// hull engine: pivot search, rank sort by angle, graham scan, vertex output
// depends on gh_pkg and gh_orient
module gh_back import gh_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  job_t                  q_job,
    output logic                  q_pop,
    output logic                  busy,
    output logic                  pt_re,
    output logic [IDX_BITS-1:0]   pt_raddr,
    input  point_t                pt_rdata,
    output logic                  so_we,
    output logic [IDX_BITS-1:0]   so_waddr,
    output point_t                so_wdata,
    output logic                  so_re,
    output logic [IDX_BITS-1:0]   so_raddr,
    input  point_t                so_rdata,
    output logic                  st_we,
    output logic [IDX_BITS-1:0]   st_waddr,
    output point_t                st_wdata,
    output logic                  st_re,
    output logic [IDX_BITS-1:0]   st_raddr,
    input  point_t                st_rdata,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_BITS-1:0] m_hx,
    output logic [COORD_BITS-1:0] m_hy,
    output logic                  m_last_vertex,
    output logic                  m_overflowed
);

    back_state_t         state_reg, state_next;
    logic [CNT_BITS-1:0] n_reg, n_next;
    logic                ovf_reg, ovf_next;
    logic [IDX_BITS-1:0] piv_reg, piv_next;
    point_t              pv_reg, pv_next;
    point_t              best_reg, best_next;
    logic [CNT_BITS-1:0] rd_cnt_reg, rd_cnt_next;
    logic                dv_reg, dv_next;
    logic [IDX_BITS-1:0] didx_reg, didx_next;
    logic [CNT_BITS-1:0] i_reg, i_next;
    point_t              pi_reg, pi_next;
    logic [L1_BITS-1:0]  di_reg, di_next;
    logic [CNT_BITS-1:0] rank_reg, rank_next;
    logic [CNT_BITS-1:0] res_reg, res_next;
    logic                sd1_skip_reg, sd1_tie_reg, sd2_skip_reg, sd2_tie_reg;
    logic                skip_now, tie_now;
    logic [CNT_BITS-1:0] top_reg, top_next;
    point_t              t0_reg, t0_next, t1_reg, t1_next, c_reg, c_next;
    logic [CNT_BITS-1:0] e_reg, e_next;
    logic                m_valid_reg, m_valid_next;
    point_t              mpt_reg, mpt_next;
    logic                mlast_reg, mlast_next;
    logic                movf_reg, movf_next;

    logic                or_in_valid, or_out_valid, or_pos, or_zero;
    point_t              or_o, or_a, or_b;
    logic [L1_BITS-1:0]  dj;
    logic                i_last, do_push;

    // taxicab distance, used to order points lying on one ray from the pivot
    function automatic logic [L1_BITS-1:0] l1_dist(point_t p, point_t q);
        logic signed [DIFF_BITS-1:0] dx, dy;
        logic [DIFF_BITS-1:0]        ax, ay;
        dx = DIFF_BITS'(p.x) - DIFF_BITS'(q.x);
        dy = DIFF_BITS'(p.y) - DIFF_BITS'(q.y);
        ax = dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
        ay = dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
        return L1_BITS'(ax) + L1_BITS'(ay);
    endfunction

    // lower y first, then lower x
    function automatic logic below(point_t p, point_t q);
        return (p.y < q.y) || ((p.y == q.y) && (p.x < q.x));
    endfunction

    gh_orient u_orient (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (or_in_valid),
        .o         (or_o),
        .a         (or_a),
        .b         (or_b),
        .out_valid (or_out_valid),
        .out_pos   (or_pos),
        .out_zero  (or_zero)
    );

    assign dj       = l1_dist(pt_rdata, pv_reg);
    assign skip_now = (didx_reg == piv_reg) || (didx_reg == i_reg[IDX_BITS-1:0]);
    assign tie_now  = (dj < di_reg) || ((dj == di_reg) && (didx_reg < i_reg[IDX_BITS-1:0]));
    assign i_last   = ((i_reg + CNT_BITS'(1)) == n_reg);

    assign busy          = (state_reg != B_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_hx          = mpt_reg.x;
    assign m_hy          = mpt_reg.y;
    assign m_last_vertex = mlast_reg;
    assign m_overflowed  = movf_reg;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        ovf_next     = ovf_reg;
        piv_next     = piv_reg;
        pv_next      = pv_reg;
        best_next    = best_reg;
        rd_cnt_next  = rd_cnt_reg;
        dv_next      = 1'b0;
        didx_next    = didx_reg;
        i_next       = i_reg;
        pi_next      = pi_reg;
        di_next      = di_reg;
        rank_next    = rank_reg;
        res_next     = res_reg;
        top_next     = top_reg;
        t0_next      = t0_reg;
        t1_next      = t1_reg;
        c_next       = c_reg;
        e_next       = e_reg;
        m_valid_next = m_valid_reg && !m_ready;
        mpt_next     = mpt_reg;
        mlast_next   = mlast_reg;
        movf_next    = movf_reg;
        q_pop        = 1'b0;
        pt_re        = 1'b0;
        pt_raddr     = rd_cnt_reg[IDX_BITS-1:0];
        so_we        = 1'b0;
        so_waddr     = rank_reg[IDX_BITS-1:0];
        so_wdata     = pi_reg;
        so_re        = 1'b0;
        so_raddr     = i_reg[IDX_BITS-1:0];
        st_we        = 1'b0;
        st_waddr     = top_reg[IDX_BITS-1:0];
        st_wdata     = c_reg;
        st_re        = 1'b0;
        st_raddr     = e_reg[IDX_BITS-1:0];
        or_in_valid  = 1'b0;
        or_o         = t0_reg;
        or_a         = t1_reg;
        or_b         = c_reg;
        do_push      = 1'b0;

        unique case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    q_pop       = 1'b1;
                    n_next      = q_job.n;
                    ovf_next    = q_job.ovf;
                    rd_cnt_next = '0;
                    state_next  = B_PIV;
                end
            end
            // stream the store once to find the pivot
            B_PIV: begin
                if (rd_cnt_reg != n_reg) begin
                    pt_re       = 1'b1;
                    dv_next     = 1'b1;
                    didx_next   = rd_cnt_reg[IDX_BITS-1:0];
                    rd_cnt_next = rd_cnt_reg + CNT_BITS'(1);
                end
                if (dv_reg && ((didx_reg == '0) || below(pt_rdata, best_reg))) begin
                    best_next = pt_rdata;
                    piv_next  = didx_reg;
                end
                if ((rd_cnt_reg == n_reg) && !dv_reg) begin
                    pv_next    = best_reg;
                    i_next     = '0;
                    state_next = B_LDI;
                end
            end
            // pick the next point to place; the pivot goes to slot zero
            B_LDI: begin
                if (i_reg[IDX_BITS-1:0] == piv_reg) begin
                    so_we    = 1'b1;
                    so_waddr = '0;
                    so_wdata = pv_reg;
                    i_next   = i_reg + CNT_BITS'(1);
                    if (i_last) begin
                        i_next     = '0;
                        top_next   = '0;
                        state_next = B_SRD;
                    end
                end else begin
                    pt_re      = 1'b1;
                    pt_raddr   = i_reg[IDX_BITS-1:0];
                    state_next = B_LDW;
                end
            end
            B_LDW: begin
                pi_next     = pt_rdata;
                di_next     = l1_dist(pt_rdata, pv_reg);
                rd_cnt_next = '0;
                res_next    = '0;
                rank_next   = CNT_BITS'(1);
                state_next  = B_RANK;
            end
            // count the points that sort ahead of this one
            B_RANK: begin
                if (rd_cnt_reg != n_reg) begin
                    pt_re       = 1'b1;
                    dv_next     = 1'b1;
                    didx_next   = rd_cnt_reg[IDX_BITS-1:0];
                    rd_cnt_next = rd_cnt_reg + CNT_BITS'(1);
                end
                or_in_valid = dv_reg;
                or_o        = pv_reg;
                or_a        = pt_rdata;
                or_b        = pi_reg;
                if (or_out_valid) begin
                    res_next = res_reg + CNT_BITS'(1);
                    if (!sd2_skip_reg && (or_pos || (or_zero && sd2_tie_reg))) begin
                        rank_next = rank_reg + CNT_BITS'(1);
                    end
                    if ((res_reg + CNT_BITS'(1)) == n_reg) begin
                        state_next = B_WRS;
                    end
                end
            end
            B_WRS: begin
                so_we  = 1'b1;
                i_next = i_reg + CNT_BITS'(1);
                if (i_last) begin
                    i_next     = '0;
                    top_next   = '0;
                    state_next = B_SRD;
                end else begin
                    state_next = B_LDI;
                end
            end
            // scan: fetch the next sorted point
            B_SRD: begin
                so_re      = 1'b1;
                state_next = B_SWT;
            end
            B_SWT: begin
                c_next     = so_rdata;
                state_next = B_TEST;
            end
            B_TEST: begin
                if (top_reg < CNT_BITS'(2)) begin
                    do_push = 1'b1;
                end else begin
                    or_in_valid = 1'b1;
                    state_next  = B_OWAIT;
                end
            end
            // left turn keeps the stack, otherwise pop
            B_OWAIT: begin
                if (or_out_valid) begin
                    if (or_pos) begin
                        do_push = 1'b1;
                    end else begin
                        top_next = top_reg - CNT_BITS'(1);
                        t1_next  = t0_reg;
                        if (top_reg >= CNT_BITS'(3)) begin
                            st_re      = 1'b1;
                            st_raddr   = IDX_BITS'(top_reg - CNT_BITS'(3));
                            state_next = B_POPW;
                        end else begin
                            state_next = B_TEST;
                        end
                    end
                end
            end
            B_POPW: begin
                t0_next    = st_rdata;
                state_next = B_TEST;
            end
            // vertex output
            B_ERD: begin
                st_re      = 1'b1;
                state_next = B_EWT;
            end
            B_EWT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    mpt_next     = st_rdata;
                    movf_next    = ovf_reg;
                    mlast_next   = ((e_reg + CNT_BITS'(1)) == top_reg);
                    e_next       = e_reg + CNT_BITS'(1);
                    state_next   = ((e_reg + CNT_BITS'(1)) == top_reg) ? B_IDLE : B_ERD;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase

        // push the current point onto the hull stack
        if (do_push) begin
            st_we    = 1'b1;
            t0_next  = t1_reg;
            t1_next  = c_reg;
            top_next = top_reg + CNT_BITS'(1);
            i_next   = i_reg + CNT_BITS'(1);
            if (i_last) begin
                e_next     = '0;
                state_next = B_ERD;
            end else begin
                state_next = B_SRD;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            dv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dv_reg      <= dv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        ovf_reg      <= ovf_next;
        piv_reg      <= piv_next;
        pv_reg       <= pv_next;
        best_reg     <= best_next;
        rd_cnt_reg   <= rd_cnt_next;
        didx_reg     <= didx_next;
        i_reg        <= i_next;
        pi_reg       <= pi_next;
        di_reg       <= di_next;
        rank_reg     <= rank_next;
        res_reg      <= res_next;
        top_reg      <= top_next;
        t0_reg       <= t0_next;
        t1_reg       <= t1_next;
        c_reg        <= c_next;
        e_reg        <= e_next;
        mpt_reg      <= mpt_next;
        mlast_reg    <= mlast_next;
        movf_reg     <= movf_next;
        sd1_skip_reg <= skip_now;
        sd1_tie_reg  <= tie_now;
        sd2_skip_reg <= sd1_skip_reg;
        sd2_tie_reg  <= sd1_tie_reg;
    end

endmodule

@@ rtl/convex_hull_graham_scan.sv @@
// top level of the graham scan convex hull block
// depends on gh_pkg, gh_ram, gh_front, gh_queue, gh_orient, gh_back
//
//  channel  | ports                                   | beat
//  ---------+-----------------------------------------+-----------------------------
//  input    | s_valid s_ready s_px s_py s_final_point | one point, final marks set end
//  result   | m_valid m_ready m_hx m_hy m_last_vertex | one hull vertex, ccw from pivot
//           | m_overflowed                            |
//
// points load at one per cycle into the point store while the loader is not held off.
// after the final point, with n stored points, the engine runs a pivot search, then an angle
// sort (one compare per cycle through the shared orientation unit and the single point
// store read port), then the scan with its pushes and pops, then the vertex output, which
// waits while the result side stalls.
// input is held off from the final point until the last vertex has left the engine.
// reset is synchronous and clears the control state; no clearing pass is needed.
module convex_hull_graham_scan import gh_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_px,
    input  logic [COORD_BITS-1:0] s_py,
    input  logic                  s_final_point,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_BITS-1:0] m_hx,
    output logic [COORD_BITS-1:0] m_hy,
    output logic                  m_last_vertex,
    output logic                  m_overflowed
);

    logic                pt_we, pt_re;
    logic [IDX_BITS-1:0] pt_waddr, pt_raddr;
    point_t              pt_wdata, pt_rdata;
    logic                so_we, so_re;
    logic [IDX_BITS-1:0] so_waddr, so_raddr;
    point_t              so_wdata, so_rdata;
    logic                st_we, st_re;
    logic [IDX_BITS-1:0] st_waddr, st_raddr;
    point_t              st_wdata, st_rdata;
    logic                push, q_full, q_valid, q_pop, busy, hold;
    job_t                push_job, q_job;

    // loader waits while a job is queued or running
    assign hold = q_full || q_valid || busy;

    gh_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_px          (s_px),
        .s_py          (s_py),
        .s_final_point (s_final_point),
        .hold          (hold),
        .pt_we         (pt_we),
        .pt_waddr      (pt_waddr),
        .pt_wdata      (pt_wdata),
        .push          (push),
        .push_job      (push_job)
    );

    gh_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_job  (q_job)
    );

    // point store
    gh_ram #(.WIDTH(PT_BITS), .DEPTH(MAX_POINTS)) u_pt_ram (
        .aclk  (aclk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .re    (pt_re),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    // points in angular order
    gh_ram #(.WIDTH(PT_BITS), .DEPTH(MAX_POINTS)) u_so_ram (
        .aclk  (aclk),
        .we    (so_we),
        .waddr (so_waddr),
        .wdata (so_wdata),
        .re    (so_re),
        .raddr (so_raddr),
        .rdata (so_rdata)
    );

    // hull stack
    gh_ram #(.WIDTH(PT_BITS), .DEPTH(MAX_POINTS)) u_st_ram (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    gh_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_job         (q_job),
        .q_pop         (q_pop),
        .busy          (busy),
        .pt_re         (pt_re),
        .pt_raddr      (pt_raddr),
        .pt_rdata      (pt_rdata),
        .so_we         (so_we),
        .so_waddr      (so_waddr),
        .so_wdata      (so_wdata),
        .so_re         (so_re),
        .so_raddr      (so_raddr),
        .so_rdata      (so_rdata),
        .st_we         (st_we),
        .st_waddr      (st_waddr),
        .st_wdata      (st_wdata),
        .st_re         (st_re),
        .st_raddr      (st_raddr),
        .st_rdata      (st_rdata),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hx          (m_hx),
        .m_hy          (m_hy),
        .m_last_vertex (m_last_vertex),
        .m_overflowed  (m_overflowed)
    );

endmodule

@@ rtl/gh_checker.sv @@
// port level checks for the convex hull block, bound to the top level
// depends on gh_pkg
module gh_checker import gh_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [COORD_BITS-1:0] s_px,
    input logic [COORD_BITS-1:0] s_py,
    input logic                  s_final_point,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [COORD_BITS-1:0] m_hx,
    input logic [COORD_BITS-1:0] m_hy,
    input logic                  m_last_vertex,
    input logic                  m_overflowed
);

    // a final point closes the input right after it is taken
    a_final_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_final_point) |=> !s_ready)
        else $error("input still open after final point");

    // no new point is taken while a hull is part way out
    a_no_load_mid_hull: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last_vertex) |-> !s_ready)
        else $error("input open in the middle of a hull");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_hx) && $stable(m_hy)
            && $stable(m_last_vertex) && $stable(m_overflowed)))
        else $error("result beat changed while stalled");

    // reset empties the result side
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind convex_hull_graham_scan gh_checker u_gh_checker (.*);

@@ test/convex_hull_graham_scan_tb.sv @@
// self-checking testbench for the graham scan convex hull block
// depends on gh_pkg and the rtl top convex_hull_graham_scan; holds its own hull predictor
module convex_hull_graham_scan_tb;
    import gh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SET_TARGET = 500;

    typedef struct {
        logic [15:0] hx;
        logic [15:0] hy;
        logic        last_v;
        logic        ovf;
    } vertex_t;

    typedef struct {
        int   x;
        int   y;
        bit   fin;
        bit   typed;
    } row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [COORD_BITS-1:0] s_px = '0;
    logic [COORD_BITS-1:0] s_py = '0;
    logic                  s_final_point = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [COORD_BITS-1:0] m_hx;
    logic [COORD_BITS-1:0] m_hy;
    logic                  m_last_vertex;
    logic                  m_overflowed;

    // predictor state
    longint  set_x [MAX_POINTS];
    longint  set_y [MAX_POINTS];
    int      set_count = 0;
    bit      set_dropped = 0;
    vertex_t hull_due [$];

    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int beats_sent = 0;

    convex_hull_graham_scan u_top (.*);

    always #5 aclk = ~aclk;

    // cross product of (a - o) and (b - o)
    function automatic longint cross3(int o, int a, int b);
        return (set_x[a] - set_x[o]) * (set_y[b] - set_y[o])
             - (set_y[a] - set_y[o]) * (set_x[b] - set_x[o]);
    endfunction

    function automatic longint dist_sq(int o, int a);
        longint dx, dy;
        dx = set_x[a] - set_x[o];
        dy = set_y[a] - set_y[o];
        return dx * dx + dy * dy;
    endfunction

    function automatic bit angle_before(int piv, int a, int b);
        longint c;
        c = cross3(piv, a, b);
        if (c == 0) return dist_sq(piv, a) < dist_sq(piv, b);
        return c > 0;
    endfunction

    // store one accepted point; on the final one queue the hull vertices
    task automatic predict_point(logic [15:0] x, logic [15:0] y, bit fin);
        int order [MAX_POINTS];
        int stack [MAX_POINTS];
        int piv, k, j, top;
        vertex_t v;
        if (set_count < MAX_POINTS) begin
            set_x[set_count] = longint'($signed(x));
            set_y[set_count] = longint'($signed(y));
            set_count++;
        end else begin
            set_dropped = 1;
        end
        if (!fin) return;
        piv = 0;
        for (int i = 1; i < set_count; i++)
            if (set_y[i] < set_y[piv] || (set_y[i] == set_y[piv] && set_x[i] < set_x[piv]))
                piv = i;
        // insertion sort by angle about the pivot
        order[0] = piv;
        k = 1;
        for (int i = 0; i < set_count; i++) begin
            if (i == piv) continue;
            j = k;
            while (j > 1 && angle_before(piv, i, order[j-1])) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
            k++;
        end
        // scan, popping on any turn that is not strictly left
        top = 0;
        for (int i = 0; i < set_count; i++) begin
            while (top >= 2 && cross3(stack[top-2], stack[top-1], order[i]) <= 0)
                top--;
            stack[top] = order[i];
            top++;
        end
        for (int i = 0; i < top; i++) begin
            v.hx = set_x[stack[i]][15:0];
            v.hy = set_y[stack[i]][15:0];
            v.last_v = (i == top - 1);
            v.ovf = set_dropped;
            hull_due = {hull_due, v};
        end
        set_count = 0;
        set_dropped = 0;
    endtask

    // one input beat, with random gaps before it
    task automatic send_point(int x, int y, bit fin);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_valid = 1'b1;
        s_px = x[15:0];
        s_py = y[15:0];
        s_final_point = fin;
        do @(posedge aclk); while (!s_ready);
        predict_point(x[15:0], y[15:0], fin);
        beats_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // result side back-pressure
    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    // compare each result beat with the oldest expected vertex
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (hull_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vertex hx=%0d hy=%0d", $signed(m_hx), $signed(m_hy));
            end else begin
                vertex_t e;
                e = hull_due.pop_front();
                if (m_hx !== e.hx || m_hy !== e.hy || m_last_vertex !== e.last_v
                    || m_overflowed !== e.ovf) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("vertex mismatch exp (%0d,%0d,l%0b,o%0b) got (%0d,%0d,l%0b,o%0b)",
                                 $signed(e.hx), $signed(e.hy), e.last_v, e.ovf,
                                 $signed(m_hx), $signed(m_hy), m_last_vertex, m_overflowed);
                end
            end
        end
    end

    // hang guard
    initial begin
        #20ms;
        $display("** convex_hull_graham_scan: FAILED **");
        $finish;
    end

    // directed sets: single points at both extremes and at the origin, square with inner point,
    // collinear line, repeated pivot, all points equal, triangle
    row_t directed [] = '{
        '{-32768, -32768, 1, 1}, '{32767, 32767, 1, 1}, '{0, 0, 1, 1},
        '{0, 0, 0, 0}, '{10, 0, 0, 0}, '{10, 10, 0, 0}, '{0, 10, 0, 0}, '{5, 5, 1, 0},
        '{1, 1, 0, 0}, '{3, 3, 0, 0}, '{2, 2, 0, 0}, '{-4, -4, 1, 0},
        '{-32768, 32767, 0, 0}, '{32767, -32768, 0, 0}, '{32767, -32768, 0, 0},
        '{0, 0, 1, 0},
        '{7, -7, 0, 0}, '{7, -7, 0, 0}, '{7, -7, 1, 0},
        '{2, 0, 0, 0}, '{-2, 0, 0, 0}, '{0, 3, 1, 0}
    };

    initial begin
        int n, mode, dx, dy, ox, oy, px, py, phase, waited;
        vertex_t v;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed part, single-point rows carry their hull written out
        foreach (directed[i]) begin
            if (directed[i].typed) begin
                v.hx = directed[i].x[15:0];
                v.hy = directed[i].y[15:0];
                v.last_v = 1'b1;
                v.ovf = 1'b0;
                send_point(directed[i].x, directed[i].y, directed[i].fin);
                if (hull_due.size() == 0 || hull_due[$].hx !== v.hx
                    || hull_due[$].hy !== v.hy || hull_due[$].last_v !== v.last_v
                    || hull_due[$].ovf !== v.ovf) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("single point hull exp (%0d,%0d,l1,o0), %0d queued",
                                 directed[i].x, directed[i].y, hull_due.size());
                end
            end else begin
                send_point(directed[i].x, directed[i].y, directed[i].fin);
            end
        end

        // random sets in four idling phases
        for (phase = 0; phase < 4; phase++) begin
            // hold the sender until the hull pipe has drained
            while (hull_due.size() != 0) @(negedge aclk);
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            while (beats_sent < SET_TARGET * (phase + 1) / 4 + directed.size()) begin
                n = ($urandom_range(29) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
                mode = $urandom_range(3);
                dx = $urandom_range(7) - 3;
                dy = $urandom_range(7) - 3;
                ox = $urandom_range(200) - 100;
                oy = $urandom_range(200) - 100;
                for (int i = 0; i < n; i++) begin
                    case (mode)
                        0, 1: begin
                            px = int'($signed(16'($urandom())));
                            py = int'($signed(16'($urandom())));
                        end
                        2: begin
                            px = $urandom_range(6) - 3;
                            py = $urandom_range(6) - 3;
                        end
                        default: begin
                            // points on one line, with repeats
                            waited = $urandom_range(8) - 4;
                            px = ox + waited * dx;
                            py = oy + waited * dy;
                        end
                    endcase
                    send_point(px, py, i == n - 1);
                end
            end
        end

        while (hull_due.size() != 0) @(negedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && hull_due.size() == 0) begin
            $display("** convex_hull_graham_scan: PASSED **");
        end else begin
            $display("** convex_hull_graham_scan: FAILED **");
        end
        $finish;
    end
endmodule
